@@ rtl/pf_pkg.sv @@
// ----------------------------------------------------------------------------
// pf_pkg: shared types for the prime factorization unit
// Result width and the status bundle of the shared divider.
// ----------------------------------------------------------------------------
package pf_pkg;

	// Width of one emitted factor
	localparam int unsigned FACTOR_W = 32;

	// Status of the iterative divider, seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/pf_div.sv @@
// ----------------------------------------------------------------------------
// pf_div: iterative restoring divider
// One quotient bit per cycle; gives quotient and remainder of dividend/divisor.
// ----------------------------------------------------------------------------
module pf_div #(
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned DIV_BITS   = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0]   divisor,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [DIV_BITS-1:0]   remainder,
	output pf_pkg::div_stat_t     stat
);

	localparam int unsigned CW = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] quo_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIV_BITS:0]     shifted;
	logic [DIV_BITS+1:0]   diff;
	logic                  ge;

	// One restoring step: shift in the next dividend bit, try to subtract
	assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};
	assign ge      = ~diff[DIV_BITS+1];

	// Control: bit counter and busy/done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// Checks
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("pf_div: done while busy");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0 && !start) |=> done_q)
		else $error("pf_div: final step did not signal done");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < divisor))
		else $error("pf_div: remainder not below divisor");

endmodule

@@ rtl/prime_factorization_unit.sv @@
// ----------------------------------------------------------------------------
// prime_factorization_unit: trial division prime factorization
// Emits the prime factors of each request in ascending order, one per result.
// ----------------------------------------------------------------------------
// Each trial division runs in the shared radix-2 divider (one quotient bit
// per cycle); a request needs one division per divisor tried plus one per
// factor found, so up to about 2^(VALUE_BITS/2-1) divisions for a large
// prime. One request is worked at a time; in_ready is high only when idle.
// After asynchronous reset the unit is idle, ready, and holds no result.
module prime_factorization_unit #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [VALUE_BITS-1:0]       value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pf_pkg::FACTOR_W-1:0] factor,
	output logic                        last
);

	// Divisors never exceed about sqrt(2^VALUE_BITS) + 2
	localparam int unsigned DW = VALUE_BITS / 2 + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_EVAL = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                      state_q, state_d;
	logic [VALUE_BITS-1:0]       x_q, x_d;
	logic [DW-1:0]               d_q, d_d;
	logic                        inner_q, inner_d;
	logic [DW-1:0]               pend_q, pend_d;
	logic                        pend_v_q, pend_v_d;
	logic                        out_valid_q;
	logic [pf_pkg::FACTOR_W-1:0] factor_q;
	logic                        last_q;

	logic                        push;
	logic [pf_pkg::FACTOR_W-1:0] push_factor;
	logic                        push_last;
	logic                        out_free;
	logic                        x_is_one;

	logic                        div_start;
	logic [VALUE_BITS-1:0]       div_dividend;
	logic [VALUE_BITS-1:0]       div_quo;
	logic [DW-1:0]               div_rem;
	pf_pkg::div_stat_t           div_stat;

	// Shared divider: quotient and remainder of x by the current divisor
	pf_div #(
		.VALUE_BITS(VALUE_BITS),
		.DIV_BITS  (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (d_q),
		.quotient (div_quo),
		.remainder(div_rem),
		.stat     (div_stat)
	);

	assign out_free = !out_valid_q || out_ready;
	assign x_is_one = (x_q == VALUE_BITS'(1));
	assign in_ready = (state_q == S_IDLE);

	// Sequencer. The newest factor is held back as pending until the next one
	// (or the end of the request) shows whether it is the last.
	always_comb begin
		state_d      = state_q;
		x_d          = x_q;
		d_d          = d_q;
		inner_d      = inner_q;
		pend_d       = pend_q;
		pend_v_d     = pend_v_q;
		push         = 1'b0;
		push_factor  = pf_pkg::FACTOR_W'(pend_q);
		push_last    = 1'b0;
		div_start    = 1'b0;
		div_dividend = x_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					x_d          = value;
					d_d          = DW'(2);
					inner_d      = 1'b0;
					pend_v_d     = 1'b0;
					div_start    = 1'b1;
					div_dividend = value;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				priority if (!inner_q && (div_quo < VALUE_BITS'(d_q))) begin
					// divisor squared exceeds what is left
					state_d = S_FIN;
				end else if (div_rem == '0) begin
					// divisor divides: record it, keep dividing by it
					if (!pend_v_q || out_free) begin
						push         = pend_v_q;
						pend_d       = d_q;
						pend_v_d     = 1'b1;
						x_d          = div_quo;
						inner_d      = 1'b1;
						div_start    = 1'b1;
						div_dividend = div_quo;
						state_d      = S_DIV;
					end
				end else begin
					// next candidate: 2, then odd numbers
					d_d       = (d_q == DW'(2)) ? DW'(3) : d_q + DW'(2);
					inner_d   = 1'b0;
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_FIN: begin
				if (out_free) begin
					if (pend_v_q) begin
						push      = 1'b1;
						push_last = x_is_one;
						pend_v_d  = 1'b0;
						if (x_is_one) begin
							state_d = S_IDLE;
						end
					end else begin
						// leftover cofactor above one (or zero) is the last factor
						push        = !x_is_one;
						push_factor = pf_pkg::FACTOR_W'(x_q);
						push_last   = 1'b1;
						state_d     = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_v_q    <= 1'b0;
			inner_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pend_v_q <= pend_v_d;
			inner_q  <= inner_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working values and result register
	always_ff @(posedge clk) begin
		x_q    <= x_d;
		d_q    <= d_d;
		pend_q <= pend_d;
		if (push) begin
			factor_q <= push_factor;
			last_q   <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign factor    = factor_q;
	assign last      = last_q;

	// Checks
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pf: pending factor left over at end of request");

	a_divisor_form: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> (d_q[0] || d_q == DW'(2)))
		else $error("pf: divisor neither two nor odd");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("pf: divider started while busy");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("pf: result overwritten before taken");

endmodule
